/* design/cms_pkg.sv */
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, widths and helper functions for the counter multiplex scaler.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int MAX_EVENTS  = 4;
    localparam int COUNT_WIDTH = 32;
    localparam int SLICE_W     = 8;
    localparam int SUM_WIDTH   = COUNT_WIDTH + SLICE_W;
    localparam int EV_W        = $clog2(MAX_EVENTS);
    localparam int EVCFG_W     = 3;
    localparam int OUT_W       = 40;
    localparam int PROD_W      = SUM_WIDTH + SLICE_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_EVENTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLICES   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // events_in_use clamped to 1..MAX_EVENTS
    function automatic logic [EVCFG_W-1:0] eff_events(input logic [EVCFG_W-1:0] v);
        logic [EVCFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = EVCFG_W'(1);
        end else if (v > EVCFG_W'(MAX_EVENTS)) begin
            r = EVCFG_W'(MAX_EVENTS);
        end
        return r;
    endfunction

    // rotation modulo the event count, both small
    function automatic logic [EV_W-1:0] mod_ev(input logic [EV_W-1:0] rot,
                                               input logic [EVCFG_W-1:0] ev);
        logic [EVCFG_W-1:0] r;
        r = EVCFG_W'(rot);
        for (int k = 0; k < MAX_EVENTS; k++) begin
            if (r >= ev) begin
                r = r - ev;
            end
        end
        return r[EV_W-1:0];
    endfunction

endpackage

/* design/cms_if.sv */
// ----------------------------------------------------------------------------
// cms_if
// Handshake channels of the counter multiplex scaler: slice in, result out,
// configuration write.
// ----------------------------------------------------------------------------
interface cms_slice_if;
    logic                            valid;
    logic                            ready;
    logic [cms_pkg::COUNT_WIDTH-1:0] slice_count_0;
    logic [cms_pkg::COUNT_WIDTH-1:0] slice_count_1;
    logic [cms_pkg::COUNT_WIDTH-1:0] slice_count_2;
    logic [cms_pkg::COUNT_WIDTH-1:0] slice_count_3;

    modport source (output valid, output slice_count_0, output slice_count_1,
                    output slice_count_2, output slice_count_3, input ready);
    modport sink   (input valid, input slice_count_0, input slice_count_1,
                    input slice_count_2, input slice_count_3, output ready);
endinterface

interface cms_result_if;
    logic                        valid;
    logic                        ready;
    logic [cms_pkg::EV_W-1:0]    event_index;
    logic [cms_pkg::OUT_W-1:0]   true_total;
    logic [cms_pkg::OUT_W-1:0]   raw_total;
    logic [cms_pkg::SLICE_W-1:0] running_slices;
    logic [cms_pkg::OUT_W-1:0]   scaled_estimate;
    logic                        no_coverage;
    logic                        last_of_run;

    modport source (output valid, output event_index, output true_total,
                    output raw_total, output running_slices, output scaled_estimate,
                    output no_coverage, output last_of_run, input ready);
    modport sink   (input valid, input event_index, input true_total,
                    input raw_total, input running_slices, input scaled_estimate,
                    input no_coverage, input last_of_run, output ready);
endinterface

interface cms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cms_pkg::CFG_IDX_W-1:0]  index;
    logic [cms_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/cms_div.sv */
// ----------------------------------------------------------------------------
// cms_div
// Radix-2 restoring divider, one quotient bit per cycle, for the estimate.
// ----------------------------------------------------------------------------
module cms_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cms_pkg::PROD_W-1:0]     i_dividend,
    input  logic [cms_pkg::SLICE_W-1:0]    i_divisor,
    output logic [cms_pkg::PROD_W-1:0]     o_quotient,
    output cms_pkg::t_div_stat             o_stat
);

    logic [cms_pkg::PROD_W-1:0]    r_acc;
    logic [cms_pkg::SLICE_W-1:0]   r_rem;
    logic [cms_pkg::SLICE_W-1:0]   r_div;
    logic [cms_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [cms_pkg::SLICE_W:0]     trial;
    logic                          q_bit;
    logic [cms_pkg::SLICE_W:0]     diff;

    // shift in next dividend bit and try a subtract
    assign trial = {r_rem, r_acc[cms_pkg::PROD_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cms_pkg::DIV_CNT_W'(cms_pkg::PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cms_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[cms_pkg::PROD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[cms_pkg::SLICE_W-1:0] : trial[cms_pkg::SLICE_W-1:0];
        end
    end

    assign o_quotient  = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* design/counter_multiplex_scaler.sv */
// ----------------------------------------------------------------------------
// counter_multiplex_scaler
// Per-slice accumulation of true and multiplexed counts, one event per cycle,
// with end-of-run scaling through a shared serial divider.
// ----------------------------------------------------------------------------
// slice item: accepted in idle, then accumulated for each event in use in turn,
//   and the next slice is taken only once the sequencer is back in idle
// end of run: per event a multiply state and a serial divide (the divide is
//   skipped when the event never ran), then the result waits for ready
// reset: synchronous active-low, clears all sums, rotation and slice number;
//   registers return to 4 events, 2 counters, 8 slices per run
module counter_multiplex_scaler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cms_slice_if.sink    i_slice,
    cms_result_if.source o_result,
    cms_cfg_if.sink      i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ACCUM = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [cms_pkg::EVCFG_W-1:0] r_cfg_ev;
    logic [cms_pkg::EVCFG_W-1:0] r_cfg_cn;
    logic [cms_pkg::SLICE_W-1:0] r_cfg_sl;

    // run state
    logic [cms_pkg::SUM_WIDTH-1:0]   r_true [cms_pkg::MAX_EVENTS];
    logic [cms_pkg::SUM_WIDTH-1:0]   r_raw  [cms_pkg::MAX_EVENTS];
    logic [cms_pkg::SLICE_W-1:0]     r_run  [cms_pkg::MAX_EVENTS];
    logic [cms_pkg::EV_W-1:0]        r_rotation;
    logic [cms_pkg::SLICE_W-1:0]     r_slice_num;

    // per-item working registers
    logic [cms_pkg::COUNT_WIDTH-1:0] r_cnt [cms_pkg::MAX_EVENTS];
    logic [cms_pkg::EVCFG_W-1:0]     r_ev;
    logic [cms_pkg::EVCFG_W-1:0]     r_cn;
    logic [cms_pkg::SLICE_W-1:0]     r_sl;
    logic [cms_pkg::EV_W-1:0]        r_rot;
    logic [cms_pkg::EV_W-1:0]        r_idx;
    logic [cms_pkg::OUT_W-1:0]       r_est;
    logic                            r_nocov;

    logic                            slice_acc;
    logic                            out_acc;
    logic                            idx_last;
    logic [cms_pkg::EVCFG_W-1:0]     ev_now;
    logic [cms_pkg::EVCFG_W-1:0]     pos_raw;
    logic [cms_pkg::EVCFG_W-1:0]     pos;
    logic                            holds_cnt;
    logic [cms_pkg::EVCFG_W-1:0]     rot_inc;
    logic                            run_end;
    logic                            div_start;
    logic [cms_pkg::PROD_W-1:0]      div_dividend;
    logic [cms_pkg::PROD_W-1:0]      div_quotient;
    cms_pkg::t_div_stat              div_stat;

    assign slice_acc = i_slice.valid && i_slice.ready;
    assign out_acc   = o_result.valid && o_result.ready;
    assign idx_last  = ({1'b0, r_idx} == (r_ev - cms_pkg::EVCFG_W'(1)));
    assign ev_now    = cms_pkg::eff_events(r_cfg_ev);

    // position of the current event in the rotated order
    assign pos_raw   = {1'b0, r_idx} + r_ev - {1'b0, r_rot};
    assign pos       = (pos_raw >= r_ev) ? (pos_raw - r_ev) : pos_raw;
    assign holds_cnt = (pos < r_cn);
    assign rot_inc   = {1'b0, r_rot} + cms_pkg::EVCFG_W'(1);
    assign run_end   = !(({1'b0, r_slice_num} + 9'd1) < {1'b0, r_sl});

    assign div_start    = (r_state == S_MUL) && (r_run[r_idx] != '0);
    assign div_dividend = cms_pkg::PROD_W'(r_raw[r_idx]) * cms_pkg::PROD_W'(r_sl);

    cms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_run[r_idx]),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (slice_acc) n_state = S_ACCUM;
            end
            S_ACCUM: begin
                if (idx_last) n_state = run_end ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                n_state = div_start ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) n_state = idx_last ? S_IDLE : S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ev <= cms_pkg::EVCFG_W'(4);
            r_cfg_cn <= cms_pkg::EVCFG_W'(2);
            r_cfg_sl <= cms_pkg::SLICE_W'(8);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                cms_pkg::REG_EVENTS:   r_cfg_ev <= i_cfg.data[cms_pkg::EVCFG_W-1:0];
                cms_pkg::REG_COUNTERS: r_cfg_cn <= i_cfg.data[cms_pkg::EVCFG_W-1:0];
                cms_pkg::REG_SLICES:   r_cfg_sl <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // sequencer and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rotation  <= '0;
            r_slice_num <= '0;
            for (int e = 0; e < cms_pkg::MAX_EVENTS; e++) begin
                r_true[e] <= '0;
                r_raw[e]  <= '0;
                r_run[e]  <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                end
                S_ACCUM: begin
                    r_true[r_idx] <= r_true[r_idx]
                                   + cms_pkg::SUM_WIDTH'(r_cnt[r_idx]);
                    if (holds_cnt) begin
                        r_raw[r_idx] <= r_raw[r_idx] + cms_pkg::SUM_WIDTH'(r_cnt[r_idx]);
                        r_run[r_idx] <= r_run[r_idx] + 1'b1;
                    end
                    if (idx_last) begin
                        // rotation only moves when events outnumber counters
                        if (r_ev > r_cn) begin
                            r_rotation <= (rot_inc == r_ev) ? '0 : rot_inc[cms_pkg::EV_W-1:0];
                        end else begin
                            r_rotation <= r_rot;
                        end
                        r_idx <= '0;
                        if (!run_end) r_slice_num <= r_slice_num + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (idx_last) begin
                            r_idx       <= '0;
                            r_rotation  <= '0;
                            r_slice_num <= '0;
                            for (int e = 0; e < cms_pkg::MAX_EVENTS; e++) begin
                                r_true[e] <= '0;
                                r_raw[e]  <= '0;
                                r_run[e]  <= '0;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture and estimate registers
    always_ff @(posedge i_clk) begin
        if (slice_acc) begin
            r_cnt[0] <= i_slice.slice_count_0;
            r_cnt[1] <= i_slice.slice_count_1;
            r_cnt[2] <= i_slice.slice_count_2;
            r_cnt[3] <= i_slice.slice_count_3;
            r_ev     <= ev_now;
            r_cn     <= r_cfg_cn;
            r_sl     <= (r_cfg_sl == '0) ? cms_pkg::SLICE_W'(1) : r_cfg_sl;
            r_rot    <= cms_pkg::mod_ev(r_rotation, ev_now);
        end
        if (r_state == S_MUL && !div_start) begin
            r_est   <= '0;
            r_nocov <= 1'b1;
        end else if (r_state == S_DIV && div_stat.done) begin
            // estimate is bounded by slices times the count range
            r_est   <= div_quotient[cms_pkg::OUT_W-1:0];
            r_nocov <= 1'b0;
        end
    end

    assign i_slice.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;

    assign o_result.valid           = (r_state == S_OUT);
    assign o_result.event_index     = r_idx;
    assign o_result.true_total      = r_true[r_idx];
    assign o_result.raw_total       = r_raw[r_idx];
    assign o_result.running_slices  = r_run[r_idx];
    assign o_result.scaled_estimate = r_est;
    assign o_result.no_coverage     = r_nocov;
    assign o_result.last_of_run     = idx_last;

endmodule
